// File: rtl/core/njss_pkg.sv
// Shared types and constants for the nearest joint solution selector.
package njss_pkg;

    localparam int JOINTS     = 6;
    localparam int FIELD_W    = 16;
    localparam int INDEX_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HAVE_CURRENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_BASE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LAST   = 3'd6;

    typedef logic [JOINTS-1:0][FIELD_W-1:0] angle_vec_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] solution_angle_0;
        logic signed [FIELD_W-1:0] solution_angle_1;
        logic signed [FIELD_W-1:0] solution_angle_2;
        logic signed [FIELD_W-1:0] solution_angle_3;
        logic signed [FIELD_W-1:0] solution_angle_4;
        logic signed [FIELD_W-1:0] solution_angle_5;
        logic                      is_last;
    } njss_in_t;

    typedef struct packed {
        logic        [INDEX_W-1:0] sel_index;
        logic signed [FIELD_W-1:0] best_angle_0;
        logic signed [FIELD_W-1:0] best_angle_1;
        logic signed [FIELD_W-1:0] best_angle_2;
        logic signed [FIELD_W-1:0] best_angle_3;
        logic signed [FIELD_W-1:0] best_angle_4;
        logic signed [FIELD_W-1:0] best_angle_5;
        logic                      overflow;
    } njss_out_t;

    // Side data that travels with a candidate down the pipeline
    typedef struct packed {
        logic       last;
        angle_vec_t angles;
    } njss_tag_t;

endpackage

// File: rtl/core/njss_lane.sv
// One joint lane: wrapped angle difference magnitude, then its square.
module njss_lane
    import njss_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      adv,
    input  logic [FIELD_W-1:0]        angle,
    input  logic [FIELD_W-1:0]        current,
    output logic [2*ANGLE_BITS-2:0]   sq
);

    localparam int SQ_W = 2 * ANGLE_BITS - 1;

    logic [ANGLE_BITS+FIELD_W-1:0] angle_ext;
    logic [ANGLE_BITS+FIELD_W-1:0] current_ext;
    logic [ANGLE_BITS-1:0]         diff;
    logic [ANGLE_BITS-1:0]         mag_next;
    logic [ANGLE_BITS-1:0]         mag_reg;
    logic [2*ANGLE_BITS-1:0]       prod;
    logic [SQ_W-1:0]               sq_reg;

    // Keep the low ANGLE_BITS of each angle; the difference wraps mod a turn
    assign angle_ext   = {{ANGLE_BITS{angle[FIELD_W-1]}}, angle};
    assign current_ext = {{ANGLE_BITS{1'b0}}, current};
    assign diff        = angle_ext[ANGLE_BITS-1:0] - current_ext[ANGLE_BITS-1:0];

    // Fold the upper half turn back; a half turn stays at its own magnitude
    assign mag_next = diff[ANGLE_BITS-1] ? (~diff + 1'b1) : diff;

    assign prod = mag_reg * mag_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag_reg <= mag_next;
            sq_reg  <= prod[SQ_W-1:0];
        end
    end

    assign sq = sq_reg;

endmodule

// File: rtl/core/njss_merge.sv
// Adder tree over the lane squares, running argmin, and the result register.
module njss_merge
    import njss_pkg::*;
#(
    parameter int MAX_SOLUTIONS = 256,
    parameter int ANGLE_BITS    = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                have_current,
    input  logic                                in_valid,
    input  njss_tag_t                           in_tag,
    input  logic [JOINTS-1:0][2*ANGLE_BITS-2:0] sq,
    input  logic                                m_ready,
    output logic                                m_valid,
    output njss_out_t                           m_data,
    output logic                                stall
);

    localparam int PAIR_W = 2 * ANGLE_BITS;
    localparam int DIST_W = 2 * ANGLE_BITS + 1;
    localparam int CNT_W  = $clog2(MAX_SOLUTIONS + 1);
    localparam int POS_W  = $clog2(MAX_SOLUTIONS);
    localparam int NPAIR  = JOINTS / 2;

    logic                         adv;
    logic [NPAIR-1:0][PAIR_W-1:0] pair_reg;
    logic                         v3_reg;
    njss_tag_t                    tag3_reg;
    logic [DIST_W-1:0]            dist_reg;
    logic                         v4_reg;
    njss_tag_t                    tag4_reg;

    logic [CNT_W-1:0]             count_reg, count_next;
    logic [POS_W-1:0]             pos_reg, pos_next;
    logic [DIST_W-1:0]            best_cost_reg, best_cost_next;
    angle_vec_t                   best_angles_reg, best_angles_next;
    logic                         ovf_reg, ovf_next;
    logic                         at_cap, take, fire;
    logic [POS_W+INDEX_W-1:0]     pos_ext;

    logic                         m_valid_reg;
    njss_out_t                    m_data_reg;

    // Hold the whole pipe only when a finishing beat meets a full result register that is not being taken
    assign stall = v4_reg && tag4_reg.last && m_valid_reg && !m_ready;
    assign adv   = !stall;

    // Adder tree: pairs, then the total
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < NPAIR; k++) begin
                pair_reg[k] <= {1'b0, sq[2*k]} + {1'b0, sq[2*k+1]};
            end
            tag3_reg <= in_tag;
            dist_reg <= {1'b0, pair_reg[0]} + {1'b0, pair_reg[1]} + {1'b0, pair_reg[2]};
            tag4_reg <= tag3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
        end
    end

    // Compare against the best so far; drop candidates past capacity
    assign fire   = v4_reg && adv;
    assign at_cap = count_reg >= CNT_W'(MAX_SOLUTIONS);
    assign take   = (count_reg == '0) || (have_current && (dist_reg < best_cost_reg));

    always_comb begin
        count_next       = count_reg;
        pos_next         = pos_reg;
        best_cost_next   = best_cost_reg;
        best_angles_next = best_angles_reg;
        ovf_next         = ovf_reg;
        if (at_cap) begin
            ovf_next = 1'b1;
        end else begin
            if (take) begin
                best_cost_next   = dist_reg;
                pos_next         = count_reg[POS_W-1:0];
                best_angles_next = tag4_reg.angles;
            end
            count_next = count_reg + 1'b1;
        end
    end

    assign pos_ext = {{INDEX_W{1'b0}}, pos_next};

    always_ff @(posedge aclk) begin
        if (fire) begin
            best_angles_reg <= best_angles_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            pos_reg       <= '0;
            best_cost_reg <= '0;
            ovf_reg       <= 1'b0;
        end else if (fire) begin
            if (tag4_reg.last) begin
                count_reg     <= '0;
                pos_reg       <= '0;
                best_cost_reg <= '0;
                ovf_reg       <= 1'b0;
            end else begin
                count_reg     <= count_next;
                pos_reg       <= pos_next;
                best_cost_reg <= best_cost_next;
                ovf_reg       <= ovf_next;
            end
        end
    end

    // Result register: load on a finishing beat, release on handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && tag4_reg.last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && tag4_reg.last) begin
            m_data_reg.sel_index    <= pos_ext[INDEX_W-1:0];
            m_data_reg.best_angle_0 <= best_angles_next[0];
            m_data_reg.best_angle_1 <= best_angles_next[1];
            m_data_reg.best_angle_2 <= best_angles_next[2];
            m_data_reg.best_angle_3 <= best_angles_next[3];
            m_data_reg.best_angle_4 <= best_angles_next[4];
            m_data_reg.best_angle_5 <= best_angles_next[5];
            m_data_reg.overflow     <= ovf_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/core/nearest_joint_solution_select.sv
// Top level: nearest joint solution selector with six joint lanes and a merge stage.
//
//  channel | ports                      | direction | beat
//  --------+----------------------------+-----------+---------------------------------
//  input   | s_valid s_ready s_data     | in        | one candidate, six angles + last
//  result  | m_valid m_ready m_data     | out       | index, six angles, overflow
//  config  | cfg_wr_en cfg_index cfg_wr_data | in   | one register write, no wait
//
// One candidate per cycle while the pipe is not stalled. A candidate passes the
// lane difference and square registers, two adder-tree registers, and then updates
// the best-so-far; the result register of a last beat loads in that same update.
// Synchronous active-low reset clears valid bits, counters and configuration.
// s_ready drops only while a last beat sits at the compare stage and the
// previous result has not been taken.
module nearest_joint_solution_select
    import njss_pkg::*;
#(
    parameter int MAX_SOLUTIONS = 256,
    parameter int ANGLE_BITS    = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  njss_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output njss_out_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int SQ_W = 2 * ANGLE_BITS - 1;

    logic                         have_current_reg;
    angle_vec_t                   current_angle_reg;
    logic [CFG_IDX_W-1:0]         cfg_slot;

    logic                         stall, adv;
    angle_vec_t                   in_angles;
    njss_tag_t                    in_tag;
    logic                         v1_reg, v2_reg;
    njss_tag_t                    tag1_reg, tag2_reg;
    logic [JOINTS-1:0][SQ_W-1:0]  sq;

    // Configuration registers
    assign cfg_slot = cfg_index - REG_ANGLE_BASE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_current_reg  <= 1'b0;
            current_angle_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_HAVE_CURRENT) begin
                have_current_reg <= cfg_wr_data[0];
            end else if (cfg_index >= REG_ANGLE_BASE && cfg_index <= REG_ANGLE_LAST) begin
                current_angle_reg[cfg_slot] <= cfg_wr_data;
            end
        end
    end

    assign adv     = !stall;
    assign s_ready = adv;

    assign in_angles = {s_data.solution_angle_5, s_data.solution_angle_4,
                        s_data.solution_angle_3, s_data.solution_angle_2,
                        s_data.solution_angle_1, s_data.solution_angle_0};
    assign in_tag    = '{last: s_data.is_last, angles: in_angles};

    // Side data follows the two lane stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
        end
    end

    for (genvar j = 0; j < JOINTS; j++) begin : g_lane
        njss_lane #(
            .ANGLE_BITS (ANGLE_BITS)
        ) u_lane (
            .aclk    (aclk),
            .adv     (adv),
            .angle   (in_angles[j]),
            .current (current_angle_reg[j]),
            .sq      (sq[j])
        );
    end

    njss_merge #(
        .MAX_SOLUTIONS (MAX_SOLUTIONS),
        .ANGLE_BITS    (ANGLE_BITS)
    ) u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .have_current (have_current_reg),
        .in_valid     (v2_reg),
        .in_tag       (tag2_reg),
        .sq           (sq),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_data       (m_data),
        .stall        (stall)
    );

    // Input is refused only while a result waits untaken
    a_ready_low_only_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input held off without a waiting result");

    // A new result appears only at an edge where the pipe advanced
    a_result_needs_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_ready))
        else $error("result loaded during a stall");

    // A beat two stages in cannot be lost: during a stall it holds its valid bit and side data
    a_stall_holds_last: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> (v2_reg == $past(v2_reg)) && (tag2_reg == $past(tag2_reg)))
        else $error("pipeline moved during a stall");

endmodule
